/* sv/quoted_argument_tokenizer_unit_assert.svh */
// Assertion macros used by the checker of the argument tokenizer.
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define QATU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Condition that must hold in the cycle after the antecedent.
`define QATU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

/* sv/qatu_pkg.sv */
// Package with the types, codes and helpers of the argument tokenizer.
package qatu_pkg;

   localparam int LineBytes     = 256;
   localparam int LineFillWidth = $clog2(LineBytes + 1);

   localparam logic [2:0] PhSkip  = 3'd0;
   localparam logic [2:0] PhRaw   = 3'd1;
   localparam logic [2:0] PhQuote = 3'd2;
   localparam logic [2:0] PhAfter = 3'd3;
   localparam logic [2:0] PhError = 3'd4;

   localparam logic [1:0] TermComma   = 2'd0;
   localparam logic [1:0] TermNewline = 2'd1;
   localparam logic [1:0] TermEnd     = 2'd2;

   localparam logic [1:0] StOk           = 2'd0;
   localparam logic [1:0] StUnterminated = 2'd1;
   localparam logic [1:0] StBadAfter     = 2'd2;

   localparam logic [7:0] ChQuote   = 8'h22;
   localparam logic [7:0] ChComma   = 8'h2C;
   localparam logic [7:0] ChNewline = 8'h0A;

   typedef struct packed {
      logic [2:0]               phase;
      logic [7:0]               position;
      logic [7:0]               start;
      logic [7:0]               length;
      logic [7:0]               count;
      logic                     quoted;
      logic [LineFillWidth-1:0] fill;
   } state_type;

   typedef struct packed {
      logic [7:0] start;
      logic [7:0] length;
      logic [7:0] index;
      logic       quoted;
      logic [1:0] terminator;
      logic [1:0] status;
   } result_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13) || (c == 8'd32);
   endfunction

endpackage

/* sv/quoted_argument_tokenizer_unit.sv */
// Top level of the quoted comma-separated argument tokenizer.
// The block takes one character per cycle while its output is not stalled and
// turns a response line into arguments, each reported as one result transfer
// when its comma, newline or end mark arrives, or when a stray character
// follows its closing quote. A character is registered on input, decided by
// the step logic against the parser state when the output register is free,
// and any result lands in that register; the state loop sets the rate.
module quoted_argument_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_byte[7:0]
   input  logic        req_tlast,   // string_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // arg_start[7:0], arg_length[15:8], arg_index[23:16]
   output logic [4:0]  rsp_tuser    // quoted[0], terminator[2:1], status[4:3]
);
   import qatu_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_end_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       emit;
   result_type res;
   logic       rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic [4:0]  rsp_user_ff;
   logic       out_free;
   logic       fire;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   qatu_step u_step (
      .cur        (state_ff),
      .char_byte  (in_char_ff),
      .string_end (in_end_ff),
      .nxt        (state_in),
      .emit       (emit),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            state_ff <= state_in;
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_end_ff <= req_tlast;
      end
      if (fire && emit) begin
         rsp_data_ff <= {res.index, res.length, res.start};
         rsp_user_ff <= {res.status, res.terminator, res.quoted};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* sv/qatu_step.sv */
// Next-state and result logic for one character or end mark of the tokenizer.
module qatu_step (
   input  qatu_pkg::state_type  cur,
   input  logic [7:0]           char_byte,
   input  logic                 string_end,
   output qatu_pkg::state_type  nxt,
   output logic                 emit,
   output qatu_pkg::result_type res
);
   import qatu_pkg::*;

   logic       sep;
   logic [1:0] sep_term;

   assign sep      = (char_byte == ChComma) || (char_byte == ChNewline);
   assign sep_term = (char_byte == ChComma) ? TermComma : TermNewline;

   always_comb begin
      nxt = cur;
      emit = 1'b0;
      res.start = cur.start;
      res.length = cur.length;
      res.index = cur.count;
      res.quoted = cur.quoted;
      res.terminator = TermEnd;
      res.status = StOk;
      if (string_end) begin
         unique case (cur.phase) inside
            PhSkip: begin
               emit = 1'b1;
               res.start = cur.position;
               res.length = 8'd0;
               res.quoted = 1'b0;
            end
            PhRaw, PhAfter: begin
               emit = 1'b1;
            end
            PhQuote: begin
               emit = 1'b1;
               res.status = StUnterminated;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
         nxt = '0;
         nxt.phase = PhSkip;
      end else if (cur.fill < LineFillWidth'(LineBytes)) begin
         nxt.fill = cur.fill + LineFillWidth'(1);
         nxt.position = sat_inc(cur.position);
         unique case (cur.phase)
            PhSkip: begin
               if (is_blank(char_byte)) begin
                  nxt.phase = PhSkip;
               end else if (char_byte == ChQuote) begin
                  nxt.start = sat_inc(cur.position);
                  nxt.length = 8'd0;
                  nxt.quoted = 1'b1;
                  nxt.phase = PhQuote;
               end else if (sep) begin
                  emit = 1'b1;
                  res.start = cur.position;
                  res.length = 8'd0;
                  res.quoted = 1'b0;
                  res.terminator = sep_term;
               end else begin
                  nxt.start = cur.position;
                  nxt.length = 8'd1;
                  nxt.quoted = 1'b0;
                  nxt.phase = PhRaw;
               end
            end
            PhRaw: begin
               if (sep) begin
                  emit = 1'b1;
                  res.terminator = sep_term;
               end else begin
                  nxt.length = sat_inc(cur.length);
               end
            end
            PhQuote: begin
               if (char_byte == ChQuote) begin
                  nxt.phase = PhAfter;
               end else begin
                  nxt.length = sat_inc(cur.length);
               end
            end
            PhAfter: begin
               if (is_blank(char_byte)) begin
                  nxt.phase = PhAfter;
               end else if (sep) begin
                  emit = 1'b1;
                  res.terminator = sep_term;
               end else begin
                  emit = 1'b1;
                  res.terminator = TermComma;
                  res.status = StBadAfter;
                  nxt.phase = PhError;
               end
            end
            default: begin
               nxt.phase = PhError;
            end
         endcase
         // A separator closes the argument and prepares the next one.
         if (emit && (res.status == StOk)) begin
            nxt.count = (char_byte == ChNewline) ? 8'd0 : sat_inc(cur.count);
            nxt.phase = PhSkip;
            nxt.start = 8'd0;
            nxt.length = 8'd0;
            nxt.quoted = 1'b0;
         end
      end
   end

endmodule

/* sv/qatu_checker.sv */
// Port-level checker for the argument tokenizer and its bind to the top level.
`include "quoted_argument_tokenizer_unit_assert.svh"

module qatu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [4:0]  rsp_tuser
);
   import qatu_pkg::*;

   logic [1:0] term;
   logic [1:0] stat;

   assign term = rsp_tuser[2:1];
   assign stat = rsp_tuser[4:3];

   `QATU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `QATU_ASSERT_IMPLY(a_codes_legal, clock, reset, rsp_tvalid,
      ((term == TermComma) || (term == TermNewline) || (term == TermEnd)) &&
      ((stat == StOk) || (stat == StUnterminated) || (stat == StBadAfter)))
   `QATU_ASSERT_IMPLY(a_bad_after, clock, reset, rsp_tvalid && (stat == StBadAfter),
      (term == TermComma) && rsp_tuser[0])
   `QATU_ASSERT_IMPLY(a_unterminated, clock, reset, rsp_tvalid && (stat == StUnterminated),
      (term == TermEnd) && rsp_tuser[0])
   `QATU_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

endmodule

bind quoted_argument_tokenizer_unit qatu_checker u_qatu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* test/tb_top.sv */
// Testbench for the quoted argument tokenizer: directed and random lines checked by a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qatu_pkg::*;

   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChVtab   = 8'h0B;
   localparam logic [7:0] ChFeed   = 8'h0C;
   localparam logic [7:0] ChReturn = 8'h0D;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChPlain  = 8'h61;

   localparam int unsigned ItemTarget  = 1500;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned ReportCap   = 20;

   class arg_scoreboard;
      logic [2:0]  phase;
      logic [7:0]  position;
      logic [7:0]  arg_start;
      logic [7:0]  arg_length;
      logic [7:0]  arg_index;
      logic        arg_quoted;
      int unsigned line_fill;
      result_type  pending_args[$];
      int unsigned mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         phase      = PhSkip;
         position   = 8'd0;
         arg_start  = 8'd0;
         arg_length = 8'd0;
         arg_index  = 8'd0;
         arg_quoted = 1'b0;
         line_fill  = 0;
      endfunction

      function logic [7:0] bump(input logic [7:0] v);
         return v + {7'd0, v != 8'hFF};
      endfunction

      function bit blank(input logic [7:0] c);
         case (c)
            ChTab, ChVtab, ChFeed, ChReturn, ChSpace: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void push_arg(input logic [1:0] term, input logic [1:0] status);
         result_type r;
         r.start      = arg_start;
         r.length     = arg_length;
         r.index      = arg_index;
         r.quoted     = arg_quoted;
         r.terminator = term;
         r.status     = status;
         pending_args.push_back(r);
      endfunction

      function void finish_arg(input logic [7:0] c);
         logic [1:0] term;
         term = (c == ChComma) ? TermComma : TermNewline;
         push_arg(term, StOk);
         arg_index  = (term == TermNewline) ? 8'd0 : bump(arg_index);
         phase      = PhSkip;
         arg_start  = 8'd0;
         arg_length = 8'd0;
         arg_quoted = 1'b0;
      endfunction

      function void note_char(input logic [7:0] c, input logic last);
         if (last) begin
            case (phase)
               PhSkip: begin
                  arg_start  = position;
                  arg_length = 8'd0;
                  arg_quoted = 1'b0;
                  push_arg(TermEnd, StOk);
               end
               PhRaw, PhAfter: push_arg(TermEnd, StOk);
               PhQuote: push_arg(TermEnd, StUnterminated);
               default: ;
            endcase
            restart();
            return;
         end
         if (line_fill >= LineBytes) return;
         line_fill++;
         case (phase)
            PhSkip: begin
               if (!blank(c)) begin
                  if (c == ChQuote) begin
                     arg_start  = bump(position);
                     arg_length = 8'd0;
                     arg_quoted = 1'b1;
                     phase      = PhQuote;
                  end else if (c == ChComma || c == ChNewline) begin
                     arg_start  = position;
                     arg_length = 8'd0;
                     arg_quoted = 1'b0;
                     finish_arg(c);
                  end else begin
                     arg_start  = position;
                     arg_length = 8'd1;
                     arg_quoted = 1'b0;
                     phase      = PhRaw;
                  end
               end
            end
            PhRaw: begin
               if (c == ChComma || c == ChNewline) finish_arg(c);
               else arg_length = bump(arg_length);
            end
            PhQuote: begin
               if (c == ChQuote) phase = PhAfter;
               else arg_length = bump(arg_length);
            end
            PhAfter: begin
               if (!blank(c)) begin
                  if (c == ChComma || c == ChNewline) begin
                     finish_arg(c);
                  end else begin
                     push_arg(TermComma, StBadAfter);
                     phase = PhError;
                  end
               end
            end
            default: phase = PhError;
         endcase
         position = bump(position);
      endfunction

      task report(input string what);
         if (mismatches < ReportCap) $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_arg(input logic [23:0] data, input logic [4:0] user);
         result_type want;
         if (pending_args.size() == 0) begin
            report($sformatf("unexpected result transfer, data %h user %h", data, user));
            return;
         end
         want = pending_args.pop_front();
         if (data[7:0] != want.start)
            report($sformatf("start %0d, expected %0d", data[7:0], want.start));
         if (data[15:8] != want.length)
            report($sformatf("length %0d, expected %0d", data[15:8], want.length));
         if (data[23:16] != want.index)
            report($sformatf("index %0d, expected %0d", data[23:16], want.index));
         if (user[0] != want.quoted)
            report($sformatf("quoted %0d, expected %0d", user[0], want.quoted));
         if (user[2:1] != want.terminator)
            report($sformatf("terminator %0d, expected %0d", user[2:1], want.terminator));
         if (user[4:3] != want.status)
            report($sformatf("status %0d, expected %0d", user[4:3], want.status));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tready = 1'b0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [23:0] rsp_tdata;
   wire  [4:0]  rsp_tuser;

   arg_scoreboard board = new();
   bit            steady = 1'b0;
   int unsigned   sent_items = 0;
   int unsigned   cycle_count = 0;
   logic [7:0]    line_buf[$];

   quoted_argument_tokenizer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_arg(rsp_tdata, rsp_tuser);
         rsp_tready <= steady || ($urandom_range(0, 99) >= 34);
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 4))
         0: return ChTab;
         1: return ChVtab;
         2: return ChFeed;
         3: return ChReturn;
         default: return ChSpace;
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == ChComma || c == ChNewline || c == ChQuote) c = ChPlain;
      return c;
   endfunction

   function automatic logic [7:0] quoted_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0: c = ChComma;
         1: c = ChNewline;
         default: if (c == ChQuote) c = ChComma;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] separator();
      return ($urandom_range(0, 4) == 0) ? ChNewline : ChComma;
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void add_quoted(input int unsigned n, input bit closed);
      line_buf.push_back(ChQuote);
      repeat (n) line_buf.push_back(quoted_byte());
      if (closed) line_buf.push_back(ChQuote);
   endfunction

   function automatic void build_clean_line();
      int unsigned n_args;
      int unsigned kind;
      n_args = $urandom_range(1, 6);
      for (int unsigned a = 0; a < n_args; a++) begin
         repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            repeat ($urandom_range(0, 8)) line_buf.push_back(plain_byte());
            if ($urandom_range(0, 3) == 0) line_buf.push_back(pick_blank());
         end else if (kind < 9) begin
            add_quoted($urandom_range(0, 8), 1'b1);
            repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
         end
         if (a + 1 < n_args || $urandom_range(0, 3) == 0) line_buf.push_back(separator());
      end
   endfunction

   function automatic void build_noise_line();
      logic [7:0] c;
      repeat ($urandom_range(1, 20)) begin
         case ($urandom_range(0, 7))
            0: c = ChQuote;
            1: c = ChComma;
            2: c = ChNewline;
            3: c = pick_blank();
            default: c = 8'($urandom_range(0, 255));
         endcase
         line_buf.push_back(c);
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_char(c, last);
      sent_items++;
      steady = (sent_items >= 700 && sent_items < 1000);
   endtask

   // Sends the buffered characters, then the end-of-string transfer with a random byte.
   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i], 1'b0);
      send_char(8'($urandom_range(0, 255)), 1'b1);
      line_buf.delete();
   endtask

   initial begin
      logic [7:0] c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_line();
      add_text(",\n");
      send_line();
      add_text("\t\"a,\nb\" ,x \n");
      send_line();
      add_text("\"ab");
      send_line();
      add_text("\"a\"x,\n");
      send_line();
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      send_line();
      add_text(" \"\" ");
      send_line();

      // Long lines drive the offset, length and index counters into saturation
      // and run past the line buffer limit.
      repeat (300) line_buf.push_back(plain_byte());
      send_line();
      repeat (260) line_buf.push_back(ChComma);
      send_line();
      add_quoted(270, 1'b0);
      send_line();

      while (sent_items < ItemTarget) begin
         case ($urandom_range(0, 9))
            7: build_noise_line();
            8: begin
               build_clean_line();
               add_quoted($urandom_range(0, 10), 1'b0);
            end
            9: begin
               if ($urandom_range(0, 1) == 0) begin
                  build_clean_line();
                  line_buf.push_back(ChComma);
               end
               add_quoted($urandom_range(0, 6), 1'b1);
               repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
               c = plain_byte();
               if (board.blank(c)) c = ChPlain;
               line_buf.push_back(c);
               build_noise_line();
            end
            default: build_clean_line();
         endcase
         send_line();
      end
      req_tvalid <= 1'b0;

      while (board.pending_args.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (board.mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
